>>> hdl/pcet_pkg.sv
// Package for the periodic coupled event timer: widths, register codes,
// shared types and the saturating time add. No dependencies.
`default_nettype none

package pcet_pkg;

    localparam int TIME_W    = 32;
    localparam int PDATA_W   = 32;
    localparam int PADDR_W   = 5;
    localparam int REG_IDX_W = 3;
    localparam int IVL_W     = 31;

    typedef logic [TIME_W-1:0]    time_t;
    typedef logic [REG_IDX_W-1:0] reg_idx_t;

    localparam reg_idx_t REG_START_TIME      = 3'd0;
    localparam reg_idx_t REG_STOP_TIME       = 3'd1;
    localparam reg_idx_t REG_REPEAT_PERIOD   = 3'd2;
    localparam reg_idx_t REG_FOLLOW_GAP      = 3'd3;
    localparam reg_idx_t REG_COUPLING_ENABLE = 3'd4;

    localparam logic signed [TIME_W-1:0] REPEAT_PERIOD_RST = -32'sd1;
    localparam logic [IVL_W-1:0]         FOLLOW_GAP_RST    = 31'd1;

    typedef struct packed {
        time_t                     start_time;
        time_t                     stop_time;
        logic signed [TIME_W-1:0]  repeat_period;
        logic [IVL_W-1:0]          follow_gap;
        logic                      coupling_enable;
    } cfg_t;

    typedef struct packed {
        logic  load_start;
        time_t start_value;
    } start_load_t;

    typedef struct packed {
        logic fire_main;
        logic fire_coupled;
        logic is_done;
    } report_t;

    function automatic time_t sat_add(input time_t a, input time_t b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> hdl/pcet_if.sv
// Channel interfaces for the timer: tick beats in, report beats out.
// Depends on nothing.
`default_nettype none

interface pcet_tick_if;
    logic        valid;
    logic        ready;
    logic [31:0] current_time;

    modport source (output valid, output current_time, input ready);
    modport sink   (input valid, input current_time, output ready);
endinterface

interface pcet_result_if;
    logic valid;
    logic ready;
    logic fire_main;
    logic fire_coupled;
    logic is_done;

    modport source (output valid, output fire_main, output fire_coupled, output is_done,
                    input ready);
    modport sink   (input valid, input fire_main, input fire_coupled, input is_done,
                    output ready);
endinterface

`default_nettype wire

>>> hdl/pcet_cfg.sv
// APB-style register file of the timer: five registers, readback, start load.
// Depends on pcet_pkg.
`default_nettype none

module pcet_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [pcet_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [pcet_pkg::PDATA_W-1:0]  pwdata,
    output logic      [pcet_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready,
    output pcet_pkg::cfg_t                     cfg,
    output pcet_pkg::start_load_t              start_load
);
    import pcet_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    logic     wr;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[PADDR_W-1:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            unique case (idx)
                REG_START_TIME:      cfg_next.start_time      = pwdata;
                REG_STOP_TIME:       cfg_next.stop_time       = pwdata;
                REG_REPEAT_PERIOD:   cfg_next.repeat_period   = $signed(pwdata);
                REG_FOLLOW_GAP:      cfg_next.follow_gap      = pwdata[IVL_W-1:0];
                REG_COUPLING_ENABLE: cfg_next.coupling_enable = pwdata[0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_time      <= '0;
            cfg_reg.stop_time       <= '0;
            cfg_reg.repeat_period   <= REPEAT_PERIOD_RST;
            cfg_reg.follow_gap      <= FOLLOW_GAP_RST;
            cfg_reg.coupling_enable <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_START_TIME:      prdata = cfg_reg.start_time;
            REG_STOP_TIME:       prdata = cfg_reg.stop_time;
            REG_REPEAT_PERIOD:   prdata = $unsigned(cfg_reg.repeat_period);
            REG_FOLLOW_GAP:      prdata = {1'b0, cfg_reg.follow_gap};
            REG_COUPLING_ENABLE: prdata = {{(PDATA_W-1){1'b0}}, cfg_reg.coupling_enable};
            default:             prdata = '0;
        endcase
    end

    assign cfg                    = cfg_reg;
    assign start_load.load_start  = wr && (idx == REG_START_TIME);
    assign start_load.start_value = pwdata;

endmodule

`default_nettype wire

>>> hdl/pcet_core.sv
// Timer datapath: tick input register, single-pass step logic and state,
// report output register. Depends on pcet_pkg and pcet_if.
`default_nettype none

module pcet_core (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire pcet_pkg::cfg_t         cfg,
    input  wire pcet_pkg::start_load_t  start_load,
    pcet_tick_if.sink                   tick,
    pcet_result_if.source               report
);
    import pcet_pkg::*;

    logic    in_valid_reg;
    time_t   in_time_reg;
    logic    out_valid_reg;
    report_t out_report_reg;
    time_t   next_start_reg;
    logic    expired_reg;
    logic    armed_reg;
    time_t   coupled_due_reg;

    time_t   next_start_next;
    logic    expired_next;
    logic    armed_next;
    time_t   coupled_due_next;
    report_t report_next;

    logic    advance;
    logic    main_due;
    logic    main_ok;

    assign advance    = in_valid_reg && (!out_valid_reg || report.ready);
    assign tick.ready = !in_valid_reg || advance;

    always_comb
    begin
        next_start_next          = next_start_reg;
        expired_next             = expired_reg;
        armed_next               = armed_reg;
        coupled_due_next         = coupled_due_reg;
        report_next.fire_main    = 1'b0;
        report_next.fire_coupled = 1'b0;
        main_due = (in_time_reg >= next_start_reg) && !expired_reg;
        main_ok  = (cfg.stop_time == '0) || (in_time_reg < cfg.stop_time);
        if (armed_reg)
        begin
            if (in_time_reg >= coupled_due_reg)
            begin
                report_next.fire_coupled = 1'b1;
                armed_next               = 1'b0;
            end
        end
        else if (main_due)
        begin
            report_next.fire_main = main_ok;
            if (!main_ok || cfg.repeat_period[TIME_W-1])
            begin
                expired_next = 1'b1;
            end
            if (!cfg.repeat_period[TIME_W-1])
            begin
                next_start_next = sat_add(next_start_reg, $unsigned(cfg.repeat_period));
            end
            if (main_ok && cfg.coupling_enable)
            begin
                armed_next       = 1'b1;
                coupled_due_next = sat_add(next_start_reg, {1'b0, cfg.follow_gap});
            end
        end
        report_next.is_done = expired_next && !armed_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            next_start_reg  <= '0;
            expired_reg     <= 1'b0;
            armed_reg       <= 1'b0;
            coupled_due_reg <= '0;
        end
        else
        begin
            if (tick.ready)
            begin
                in_valid_reg <= tick.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (report.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (start_load.load_start)
            begin
                next_start_reg <= start_load.start_value;
            end
            else if (advance)
            begin
                next_start_reg <= next_start_next;
            end
            if (advance)
            begin
                expired_reg     <= expired_next;
                armed_reg       <= armed_next;
                coupled_due_reg <= coupled_due_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick.ready && tick.valid)
        begin
            in_time_reg <= tick.current_time;
        end
        if (advance)
        begin
            out_report_reg <= report_next;
        end
    end

    assign report.valid        = out_valid_reg;
    assign report.fire_main    = out_report_reg.fire_main;
    assign report.fire_coupled = out_report_reg.fire_coupled;
    assign report.is_done      = out_report_reg.is_done;

endmodule

`default_nettype wire

>>> hdl/periodic_coupled_event_timer.sv
// Top level of the periodic coupled event timer: register file and datapath.
// Depends on pcet_pkg, pcet_if, pcet_cfg and pcet_core.
//
//   port     dir   beat contents
//   tick     in    current_time[31:0]
//   report   out   fire_main, fire_coupled, is_done
//   apb      in    register writes and reads, byte address 4*index
//
// One tick per cycle sustained while report is ready; a tick's report becomes valid once the
// tick has passed the input register and then the report register.
// The state update is a single compare/add pass between those two registers.
// Reset clears valids, timer state and registers to their defaults.
// A stalled report holds; the input register takes one more tick, then tick stalls.
`default_nettype none

module periodic_coupled_event_timer (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [pcet_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [pcet_pkg::PDATA_W-1:0]  pwdata,
    output logic      [pcet_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready,
    pcet_tick_if.sink                          tick,
    pcet_result_if.source                      report
);
    import pcet_pkg::*;

    cfg_t        cfg;
    start_load_t start_load;

    pcet_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .cfg        (cfg),
        .start_load (start_load)
    );

    pcet_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .start_load (start_load),
        .tick       (tick),
        .report     (report)
    );

endmodule

`default_nettype wire

>>> hdl/pcet_checker.sv
// Port-level checks of the timer, attached to the top level by bind.
// Depends on periodic_coupled_event_timer.
`default_nettype none

module pcet_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic tick_ready,
    input wire logic report_valid,
    input wire logic report_ready,
    input wire logic fire_main,
    input wire logic fire_coupled,
    input wire logic is_done
);
    logic done_seen_reg;
    logic pending_reg;
    logic beat;

    assign beat = report_valid && report_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_seen_reg <= 1'b0;
            pending_reg   <= 1'b0;
        end
        else if (beat)
        begin
            if (is_done)
            begin
                done_seen_reg <= 1'b1;
            end
            if (fire_main)
            begin
                pending_reg <= 1'b1;
            end
            else if (fire_coupled)
            begin
                pending_reg <= 1'b0;
            end
        end
    end

    a_report_hold: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid && !report_ready |=> report_valid && $stable(fire_main)
            && $stable(fire_coupled) && $stable(is_done))
        else $error("report beat changed while stalled");

    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid && done_seen_reg |-> is_done && !fire_main && !fire_coupled)
        else $error("timer fired or left done after reporting done");

    a_coupled_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid && fire_coupled |-> pending_reg && !fire_main)
        else $error("coupled event without a preceding main firing");

    a_tick_flows: assert property (@(posedge clk) disable iff (!rst_n)
        report_ready |-> tick_ready)
        else $error("tick stalled while report side is ready");

endmodule

bind periodic_coupled_event_timer pcet_checker u_pcet_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .tick_ready   (tick.ready),
    .report_valid (report.valid),
    .report_ready (report.ready),
    .fire_main    (report.fire_main),
    .fire_coupled (report.fire_coupled),
    .is_done      (report.is_done)
);

`default_nettype wire

>>> tb/periodic_coupled_event_timer_tb.sv
`timescale 1ns / 1ps
// Testbench for periodic_coupled_event_timer. It drives ticks and APB register writes,
// predicts every report beat in the bench and checks each field as the beat arrives.
// Depends on pcet_pkg, pcet_if and the timer RTL.

module periodic_coupled_event_timer_tb;
    import pcet_pkg::*;

    localparam int          CYCLE_LIMIT  = 600000;
    localparam int          RANDOM_TICKS = 1650;
    localparam int          DRAIN_PAUSE  = 4;
    localparam time_t       TIME_TOP     = 32'hFFFF_FFFF;

    typedef enum int {ENDING_ONE_SHOT, ENDING_STOP, ENDING_STOP_ONE_SHOT} ending_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    pcet_tick_if   tick_ch();
    pcet_result_if report_ch();

    periodic_coupled_event_timer uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .tick    (tick_ch),
        .report  (report_ch)
    );

    cfg_t        timer_cfg;
    time_t       nxt_start;
    logic        model_expired;
    logic        follow_armed;
    time_t       follow_due;
    report_t     pending_reports[$];
    int          errors = 0;
    int unsigned cycles = 0;
    bit          steady = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic time_t add_clamped(input time_t a, input time_t b);
        return (a > TIME_TOP - b) ? TIME_TOP : a + b;
    endfunction

    function automatic report_t advance_timer(input time_t now);
        report_t r;
        time_t   old_start;
        r = '0;
        if (follow_armed)
        begin
            if (now >= follow_due)
            begin
                r.fire_coupled = 1'b1;
                follow_armed = 1'b0;
            end
        end
        else if (now >= nxt_start && !model_expired)
        begin
            old_start = nxt_start;
            if (timer_cfg.stop_time == '0 || now < timer_cfg.stop_time)
                r.fire_main = 1'b1;
            else
                model_expired = 1'b1;
            if (!timer_cfg.repeat_period[TIME_W-1])
                nxt_start = add_clamped(nxt_start, time_t'(timer_cfg.repeat_period));
            else
                model_expired = 1'b1;
            if (r.fire_main && timer_cfg.coupling_enable)
            begin
                follow_armed = 1'b1;
                follow_due = add_clamped(old_start, {1'b0, timer_cfg.follow_gap});
            end
        end
        r.is_done = model_expired && !follow_armed;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge clk)
    begin : watch_channels
        report_t exp;
        if (rst_n)
        begin
            if (tick_ch.valid && tick_ch.ready)
                pending_reports = {pending_reports, advance_timer(tick_ch.current_time)};
            if (report_ch.valid && report_ch.ready)
            begin
                if (pending_reports.size() == 0)
                begin
                    $error("report beat with no tick waiting");
                    errors++;
                end
                else
                begin
                    exp = pending_reports.pop_front();
                    if (report_ch.fire_main !== exp.fire_main)
                    begin
                        $error("fire_main: expected %0b, got %0b", exp.fire_main,
                               report_ch.fire_main);
                        errors++;
                    end
                    if (report_ch.fire_coupled !== exp.fire_coupled)
                    begin
                        $error("fire_coupled: expected %0b, got %0b", exp.fire_coupled,
                               report_ch.fire_coupled);
                        errors++;
                    end
                    if (report_ch.is_done !== exp.is_done)
                    begin
                        $error("is_done: expected %0b, got %0b", exp.is_done,
                               report_ch.is_done);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin : report_pacing
        int hold;
        report_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            report_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            hold = pick_gap();
            if (hold > 0)
            begin
                report_ch.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
        end
    end

    task automatic send_tick(input time_t t);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick_ch.valid <= 1'b1;
        tick_ch.current_time <= t;
        @(posedge clk);
        while (!tick_ch.ready) @(posedge clk);
    endtask

    task automatic wait_drained();
        tick_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_reports.size() != 0) @(posedge clk);
        repeat (DRAIN_PAUSE) @(posedge clk);
    endtask

    task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_START_TIME:
            begin
                timer_cfg.start_time = value;
                nxt_start = value;
            end
            REG_STOP_TIME:       timer_cfg.stop_time = value;
            REG_REPEAT_PERIOD:   timer_cfg.repeat_period = value;
            REG_FOLLOW_GAP:      timer_cfg.follow_gap = value[IVL_W-1:0];
            REG_COUPLING_ENABLE: timer_cfg.coupling_enable = value[0];
            default: ;
        endcase
    endtask

    task automatic test_directed_edges();
        apb_write(REG_STOP_TIME, 32'd0);
        apb_write(REG_REPEAT_PERIOD, 32'd0);
        apb_write(REG_COUPLING_ENABLE, 32'd0);
        apb_write(REG_START_TIME, 32'd5);
        send_tick(32'd0);
        send_tick(32'd4);
        send_tick(32'd5);
        send_tick(TIME_TOP);

        apb_write(REG_REPEAT_PERIOD, 32'd10);
        apb_write(REG_START_TIME, 32'd100);
        send_tick(32'd99);
        send_tick(32'd100);
        send_tick(32'd105);
        send_tick(32'd110);

        apb_write(REG_FOLLOW_GAP, 32'd0);
        apb_write(REG_COUPLING_ENABLE, 32'd1);
        apb_write(REG_START_TIME, 32'd200);
        send_tick(32'd200);
        send_tick(32'd200);
        send_tick(32'd210);
        // drop coupling while the follow-up is still armed
        apb_write(REG_COUPLING_ENABLE, 32'd0);
        send_tick(32'd209);
        send_tick(32'd210);

        apb_write(REG_FOLLOW_GAP, 32'h8000_0003);
        apb_write(REG_COUPLING_ENABLE, 32'd1);
        apb_write(REG_START_TIME, 32'd300);
        send_tick(32'd300);
        send_tick(32'd302);
        send_tick(32'd303);
    endtask

    task automatic test_saturation();
        for (int i = REG_COUPLING_ENABLE + 1; i < 8; i++)
            apb_write(reg_idx_t'(i), $urandom);
        apb_write(REG_FOLLOW_GAP, 32'h7FFF_FFFF);
        apb_write(REG_REPEAT_PERIOD, 32'h7FFF_FFFF);
        apb_write(REG_START_TIME, 32'hFFFF_FFF0);
        send_tick(32'hFFFF_FFF0);
        send_tick(32'hFFFF_FFFE);
        send_tick(TIME_TOP);
        send_tick(TIME_TOP);
        send_tick(TIME_TOP);
    endtask

    function automatic int unsigned pick_scale();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(1, 8);
            1:       return $urandom_range(9, 200);
            2:       return $urandom_range(201, 100000);
            default: return $urandom_range(100001, 32'h7FFF_FFFF);
        endcase
    endfunction

    function automatic time_t pick_start();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return $urandom_range(0, 1000);
            3:       return TIME_TOP - $urandom_range(0, 64);
            4:       return TIME_TOP;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_period(input int unsigned scale);
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'h7FFF_FFFF;
            default: return $urandom_range(1, scale);
        endcase
    endfunction

    function automatic logic [31:0] pick_interval(input int unsigned scale);
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000 | $urandom_range(1, scale);
            default: return $urandom_range(1, scale);
        endcase
    endfunction

    function automatic time_t pick_stop(input time_t base, input int unsigned scale);
        time_t hop;
        if (base == TIME_TOP)
            return '0;
        case ($urandom_range(0, 4))
            0, 1:    return '0;
            2:       return TIME_TOP;
            default:
            begin
                hop = (scale > 32'h00FF_FFFF) ? TIME_TOP : scale * $urandom_range(20, 200);
                return add_clamped(base, hop);
            end
        endcase
    endfunction

    task automatic test_random_walk();
        int          sent;
        int          r;
        int unsigned scale;
        int unsigned back;
        time_t       t;
        sent = 0;
        while (sent < RANDOM_TICKS)
        begin
            scale = pick_scale();
            steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) != 0)
                apb_write(REG_START_TIME, pick_start());
            if ($urandom_range(0, 9) < 7)
                apb_write(REG_REPEAT_PERIOD, pick_period(scale));
            if ($urandom_range(0, 9) < 7)
                apb_write(REG_FOLLOW_GAP, pick_interval(scale));
            if ($urandom_range(0, 9) < 7)
                apb_write(REG_COUPLING_ENABLE, $urandom_range(0, 1));
            apb_write(REG_STOP_TIME, pick_stop(nxt_start, scale));
            if (follow_armed)
            begin
                if (follow_due != '0 && $urandom_range(0, 1) == 1)
                    send_tick(follow_due - 1);
                send_tick(follow_due);
                sent++;
            end
            back = $urandom_range(0, scale);
            t = (nxt_start > back) ? nxt_start - back : '0;
            repeat ($urandom_range(10, 80))
            begin
                r = $urandom_range(0, 99);
                if (r < 85)
                    t = add_clamped(t, $urandom_range(0, 2 * scale));
                else if (r < 95)
                    t = $urandom;
                else
                begin
                    back = $urandom_range(0, scale);
                    t = (t > back) ? t - back : '0;
                end
                // hold below the stop time so the timer stays alive
                if (timer_cfg.stop_time != '0 && t >= timer_cfg.stop_time)
                    t = timer_cfg.stop_time - 1;
                send_tick(t);
                sent++;
                if ($urandom_range(0, 149) == 0)
                    wait_drained();
            end
        end
        steady = 1'b0;
    endtask

    task automatic test_expiry();
        time_t   base;
        ending_t ending;
        base = $urandom_range(1000, 32'h7000_0000);
        ending = ending_t'($urandom_range(0, 2));
        apb_write(REG_COUPLING_ENABLE, (ending == ENDING_ONE_SHOT) ? 32'd1 : 32'd0);
        if (follow_armed)
            send_tick(follow_due);
        apb_write(REG_FOLLOW_GAP, 32'd7);
        case (ending)
            ENDING_ONE_SHOT:
            begin
                apb_write(REG_STOP_TIME, 32'd0);
                apb_write(REG_REPEAT_PERIOD,
                          $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h8000_0000);
                apb_write(REG_START_TIME, base);
                send_tick(base - 1);
                send_tick(base);
                send_tick(base + 3);
                send_tick(base + 7);
                send_tick(base + 100);
            end
            ENDING_STOP:
            begin
                apb_write(REG_STOP_TIME, base + 4);
                apb_write(REG_REPEAT_PERIOD, 32'd2);
                apb_write(REG_START_TIME, base);
                send_tick(base);
                send_tick(base + 2);
                send_tick(base + 4);
                send_tick(base + 6);
                send_tick(base + 9);
            end
            default:
            begin
                apb_write(REG_STOP_TIME, base);
                apb_write(REG_REPEAT_PERIOD, 32'hFFFF_FFFF);
                apb_write(REG_START_TIME, base);
                send_tick(base - 1);
                send_tick(base);
                send_tick(base + 1);
            end
        endcase
        repeat (20) send_tick($urandom);
        send_tick(TIME_TOP);
    endtask

    initial
    begin : run
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        tick_ch.valid        <= 1'b0;
        tick_ch.current_time <= '0;
        rst_n                <= 1'b0;
        timer_cfg.start_time      = '0;
        timer_cfg.stop_time       = '0;
        timer_cfg.repeat_period   = REPEAT_PERIOD_RST;
        timer_cfg.follow_gap      = FOLLOW_GAP_RST;
        timer_cfg.coupling_enable = 1'b0;
        nxt_start     = '0;
        model_expired = 1'b0;
        follow_armed  = 1'b0;
        follow_due    = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        test_saturation();
        test_random_walk();
        test_expiry();

        wait_drained();
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
